// File: hdl/dcfa_pkg.sv
// shared types and constants for the dwarf cfa action encoder
// no dependencies; imported by every module of the block
package dcfa_pkg;

	localparam int unsigned OffW = 32;
	localparam int unsigned RegW = 4;
	localparam int unsigned ByteW = 8;
	localparam int unsigned GroupW = 7;

	localparam logic [RegW-1:0] LastKnownReg = 4'd8;
	localparam logic [ByteW-1:0] OpDefCfa = 8'h0c;
	localparam logic [ByteW-RegW-1:0] OpOffsetHi = 4'h8;
	localparam logic [ByteW-RegW-1:0] OpRestoreHi = 4'hc;

	typedef enum logic [1:0] {
		KIND_DEF_CFA = 2'd0,
		KIND_SAVE    = 2'd1,
		KIND_RESTORE = 2'd2,
		KIND_UNUSED  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_REG      = 2'd1,
		ERR_CFA_NEG  = 2'd2,
		ERR_SAVE_OFF = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_HEAD = 2'd1,
		ST_REGB = 2'd2,
		ST_ULEB = 2'd3
	} state_t;

	typedef enum logic [1:0] {
		SEL_HEAD = 2'd0,
		SEL_REG  = 2'd1,
		SEL_ULEB = 2'd2
	} byte_sel_t;

	typedef struct packed {
		kind_t kind;
		err_t  err;
		logic  more;
	} seq_stat_t;

	typedef struct packed {
		logic      emit;
		logic      last;
		logic      shift;
		byte_sel_t sel;
		logic      busy;
	} seq_ctrl_t;

endpackage

// File: hdl/dwarf_cfa_action_encoder_top.sv
// channel   | signals                              | handshake
// command   | req_type, reg_num, offset            | taken when start && !busy
// result    | out_byte, last, error                | one cycle under strobe, no stall
//
// an action is registered when taken, then its bytes (1 to 7, or none for a valid
// unused kind) leave the sequencer one per cycle; busy drops as the last byte leaves
// the sequencer, and the next start is taken while that byte is on the result ports.
// ulebs come out of one shared 7-bit group unit, one group per cycle.
// reset clears the sequencer and the strobe; the receiver cannot stall.
// depends on dcfa_pkg, dcfa_uleb, dcfa_seq
module dwarf_cfa_action_encoder_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     req_type,
	input  logic [dcfa_pkg::RegW-1:0]      reg_num,
	input  logic signed [dcfa_pkg::OffW-1:0] offset,
	output logic                           strobe,
	output logic [dcfa_pkg::ByteW-1:0]     out_byte,
	output logic                           last,
	output logic [1:0]                     error
);
	import dcfa_pkg::*;

	kind_t              kind_in;
	err_t               err_in;
	logic               go;
	logic               skip;
	logic [OffW-1:0]    off_u;
	logic [OffW-1:0]    val_in;

	kind_t              kind_q;
	err_t               err_q;
	logic [RegW-1:0]    reg_q;
	logic [OffW-1:0]    val_q;

	logic [ByteW-1:0]   digit;
	logic               more;
	logic [OffW-1:0]    val_next;
	logic [ByteW-1:0]   head_byte;
	logic [ByteW-1:0]   byte_sel;

	seq_stat_t          stat;
	seq_ctrl_t          ctrl;

	logic               strobe_q;
	logic [ByteW-1:0]   out_byte_q;
	logic               last_q;
	err_t               error_q;

	assign kind_in = kind_t'(req_type);
	assign off_u   = offset;
	assign go      = start && !busy;

	always_comb begin
		err_in = ERR_NONE;
		if (reg_num > LastKnownReg) begin
			err_in = ERR_REG;
		end else if (kind_in == KIND_DEF_CFA && off_u[OffW-1]) begin
			err_in = ERR_CFA_NEG;
		end else if (kind_in == KIND_SAVE && (!off_u[OffW-1] || off_u[1:0] != 2'b00)) begin
			err_in = ERR_SAVE_OFF;
		end
	end

	assign skip = (err_in == ERR_NONE) && (kind_in == KIND_UNUSED);

	// save slots are encoded as the positive word count
	assign val_in = (kind_in == KIND_SAVE) ? ((OffW'(0) - off_u) >> 2) : off_u;

	always_ff @(posedge clk) begin
		if (go) begin
			kind_q <= kind_in;
			err_q  <= err_in;
			reg_q  <= reg_num;
			val_q  <= val_in;
		end else if (ctrl.shift) begin
			val_q  <= val_next;
		end
	end

	dcfa_uleb u_uleb (
		.val      (val_q),
		.digit    (digit),
		.more     (more),
		.val_next (val_next)
	);

	assign stat.kind = kind_q;
	assign stat.err  = err_q;
	assign stat.more = more;

	dcfa_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.skip   (skip),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	always_comb begin
		head_byte = '0;
		if (err_q == ERR_NONE) begin
			case (kind_q)
				KIND_DEF_CFA: head_byte = OpDefCfa;
				KIND_SAVE:    head_byte = {OpOffsetHi, reg_q};
				KIND_RESTORE: head_byte = {OpRestoreHi, reg_q};
				default:      head_byte = '0;
			endcase
		end
	end

	// register numbers fit one group, so the register byte never continues
	always_comb begin
		case (ctrl.sel)
			SEL_HEAD: byte_sel = head_byte;
			SEL_REG:  byte_sel = {{(ByteW-RegW){1'b0}}, reg_q};
			SEL_ULEB: byte_sel = digit;
			default:  byte_sel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctrl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			out_byte_q <= byte_sel;
			last_q     <= ctrl.last;
			error_q    <= (ctrl.sel == SEL_HEAD) ? err_q : ERR_NONE;
		end
	end

	assign busy     = ctrl.busy;
	assign strobe   = strobe_q;
	assign out_byte = out_byte_q;
	assign last     = last_q;
	assign error    = error_q;

endmodule

// File: hdl/dcfa_uleb.sv
// shared uleb128 digit unit: one 7-bit group per use
// depends on dcfa_pkg
module dcfa_uleb (
	input  logic [dcfa_pkg::OffW-1:0]  val,
	output logic [dcfa_pkg::ByteW-1:0] digit,
	output logic                       more,
	output logic [dcfa_pkg::OffW-1:0]  val_next
);
	import dcfa_pkg::*;

	always_comb begin
		val_next = val >> GroupW;
		more     = (val_next != '0);
		digit    = {more, val[GroupW-1:0]};
	end

endmodule

// File: hdl/dcfa_seq.sv
// byte sequencer: header, def_cfa register byte, then uleb groups
// depends on dcfa_pkg
module dcfa_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic                skip,
	input  dcfa_pkg::seq_stat_t stat,
	output dcfa_pkg::seq_ctrl_t ctrl
);
	import dcfa_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   head_last;

	assign head_last = (stat.err != ERR_NONE) || (stat.kind == KIND_RESTORE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (go && !skip) begin
					state_nxt = ST_HEAD;
				end
			end
			ST_HEAD: begin
				if (head_last) begin
					state_nxt = ST_IDLE;
				end else if (stat.kind == KIND_DEF_CFA) begin
					state_nxt = ST_REGB;
				end else begin
					state_nxt = ST_ULEB;
				end
			end
			ST_REGB: state_nxt = ST_ULEB;
			ST_ULEB: begin
				if (!stat.more) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl       = '0;
		ctrl.sel   = SEL_HEAD;
		ctrl.busy  = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: ctrl.emit = 1'b0;
			ST_HEAD: begin
				ctrl.emit = 1'b1;
				ctrl.last = head_last;
			end
			ST_REGB: begin
				ctrl.emit = 1'b1;
				ctrl.sel  = SEL_REG;
			end
			ST_ULEB: begin
				ctrl.emit  = 1'b1;
				ctrl.sel   = SEL_ULEB;
				ctrl.last  = !stat.more;
				ctrl.shift = 1'b1;
			end
			default: ctrl.emit = 1'b0;
		endcase
	end

endmodule

// File: hdl/dcfa_checker.sv
// port-level checks on the encoder's command and result channels
// depends on dcfa_pkg; bound to dwarf_cfa_action_encoder_top
module dcfa_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       strobe,
	input logic [dcfa_pkg::ByteW-1:0] out_byte,
	input logic                       last,
	input logic [1:0]                 error
);
	import dcfa_pkg::*;

	// an error transaction is a single zero byte that closes the action
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && error != ERR_NONE |-> last && out_byte == '0)
		else $error("error result not a single closing zero byte");

	// bytes of one action come out without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside an action's byte stream");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("byte right after the closing byte");

	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !strobe)
		else $error("result in the cycle after a command transaction");

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result without the encoder having been busy");

endmodule

bind dwarf_cfa_action_encoder_top dcfa_checker u_dcfa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.strobe   (strobe),
	.out_byte (out_byte),
	.last     (last),
	.error    (error)
);

// File: bench/dcfa_cfi_checker.sv
`timescale 1ns / 100ps
// checker for the dwarf cfa action encoder: predicts the cfi bytes of each command
// transaction and compares every result transaction against them
// depends on dcfa_pkg
module dcfa_cfi_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [1:0]                        req_type,
	input  logic [dcfa_pkg::RegW-1:0]         reg_num,
	input  logic signed [dcfa_pkg::OffW-1:0]  offset,
	input  logic                              strobe,
	input  logic [dcfa_pkg::ByteW-1:0]        out_byte,
	input  logic                              last,
	input  logic [1:0]                        error,
	output int                                fail_count,
	output int                                pending,
	output int                                action_count,
	output int                                byte_count,
	output int                                err_result_count
);
	import dcfa_pkg::*;

	typedef struct {
		logic [ByteW-1:0] data;
		logic             fin;
		err_t             err;
	} cfi_byte_t;

	cfi_byte_t cfi_due[$];

	function automatic void queue_byte(logic [ByteW-1:0] data, logic fin, err_t err);
		cfi_byte_t b;
		b.data = data;
		b.fin = fin;
		b.err = err;
		cfi_due.insert(cfi_due.size(), b);
	endfunction

	// low seven bits per group, high bit set while more groups follow
	function automatic void queue_uleb(logic [OffW-1:0] v, logic closes);
		logic [OffW-1:0] rest;
		logic [ByteW-1:0] b;
		rest = v;
		do begin
			b = {1'b0, rest[6:0]};
			rest = rest >> 7;
			if (rest != '0)
				b[7] = 1'b1;
			queue_byte(b, closes && (rest == '0), ERR_NONE);
		end while (rest != '0);
	endfunction

	function automatic void encode_action(kind_t kind, logic [RegW-1:0] regno,
			logic [OffW-1:0] off);
		if (regno > LastKnownReg) begin
			queue_byte('0, 1'b1, ERR_REG);
		end else begin
			case (kind)
				KIND_DEF_CFA: begin
					if (off[OffW-1]) begin
						queue_byte('0, 1'b1, ERR_CFA_NEG);
					end else begin
						queue_byte(OpDefCfa, 1'b0, ERR_NONE);
						queue_uleb({{(OffW-RegW){1'b0}}, regno}, 1'b0);
						queue_uleb(off, 1'b1);
					end
				end
				KIND_SAVE: begin
					if (!off[OffW-1] || off[1:0] != 2'b00) begin
						queue_byte('0, 1'b1, ERR_SAVE_OFF);
					end else begin
						queue_byte({OpOffsetHi, regno}, 1'b0, ERR_NONE);
						// negate at full width so the most negative slot stays in range
						queue_uleb((32'd0 - off) >> 2, 1'b1);
					end
				end
				KIND_RESTORE: begin
					queue_byte({OpRestoreHi, regno}, 1'b1, ERR_NONE);
				end
				default: begin
				end
			endcase
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cfi_byte_t want;
		if (!arst_n) begin
			cfi_due.delete();
			fail_count = 0;
			action_count = 0;
			byte_count = 0;
			err_result_count = 0;
			pending <= 0;
		end else begin
			// results first: a strobe here always belongs to an earlier transaction
			if (strobe) begin
				byte_count = byte_count + 1;
				if (error != ERR_NONE)
					err_result_count = err_result_count + 1;
				if (cfi_due.size() == 0) begin
					fail_count = fail_count + 1;
					$display("%0t: unexpected result byte %02h last %b error %0d",
						$time, out_byte, last, error);
				end else begin
					want = cfi_due.pop_front();
					if (out_byte !== want.data) begin
						fail_count = fail_count + 1;
						$display("%0t: out_byte expected %02h got %02h",
							$time, want.data, out_byte);
					end
					if (last !== want.fin) begin
						fail_count = fail_count + 1;
						$display("%0t: last expected %b got %b", $time, want.fin, last);
					end
					if (error !== want.err) begin
						fail_count = fail_count + 1;
						$display("%0t: error expected %0d got %0d", $time, want.err, error);
					end
				end
			end
			if (start && !busy) begin
				action_count = action_count + 1;
				encode_action(kind_t'(req_type), reg_num, offset);
			end
			pending <= cfi_due.size();
		end
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// top of the dwarf cfa action encoder bench: clock, reset, command stimulus and verdict
// depends on dcfa_pkg, dwarf_cfa_action_encoder_top and dcfa_cfi_checker
module tb;
	import dcfa_pkg::*;

	localparam int unsigned CycleLimit = 60000;
	localparam int RandomActions = 100;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] req_type;
	logic [RegW-1:0] reg_num;
	logic signed [OffW-1:0] offset;
	logic strobe;
	logic [ByteW-1:0] out_byte;
	logic last;
	logic [1:0] error;

	int fail_count;
	int pending;
	int action_count;
	int byte_count;
	int err_result_count;
	int unsigned cycle_count = 0;
	bit burst;

	dwarf_cfa_action_encoder_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.reg_num  (reg_num),
		.offset   (offset),
		.strobe   (strobe),
		.out_byte (out_byte),
		.last     (last),
		.error    (error)
	);

	dcfa_cfi_checker u_chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.req_type         (req_type),
		.reg_num          (reg_num),
		.offset           (offset),
		.strobe           (strobe),
		.out_byte         (out_byte),
		.last             (last),
		.error            (error),
		.fail_count       (fail_count),
		.pending          (pending),
		.action_count     (action_count),
		.byte_count       (byte_count),
		.err_result_count (err_result_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d bytes still due", cycle_count, pending);
			$display("Regression FAIL");
			$finish;
		end
	end

	// one command transaction; in bursts start stays high across back-to-back ones
	task automatic issue_action(input logic [1:0] kind, input logic [RegW-1:0] regno,
			input logic [OffW-1:0] off);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_type <= kind;
		reg_num <= regno;
		offset <= off;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	// hold the command side until every predicted byte has come out
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		logic [OffW-1:0] mag;
		logic [OffW-1:0] off;
		logic [1:0] kind;
		logic [RegW-1:0] regno;
		burst = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = '0;
		reg_num = '0;
		offset = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: encodings at their size limits and every rejection path
		issue_action(KIND_DEF_CFA, 4'd4, 32'd4);
		issue_action(KIND_DEF_CFA, 4'd5, 32'd0);
		issue_action(KIND_DEF_CFA, 4'd8, 32'd127);
		issue_action(KIND_DEF_CFA, 4'd0, 32'd128);
		issue_action(KIND_DEF_CFA, 4'd7, 32'h7fff_ffff);
		issue_action(KIND_DEF_CFA, 4'd4, 32'hffff_ffff);
		issue_action(KIND_DEF_CFA, 4'd4, 32'h8000_0000);
		issue_action(KIND_SAVE, 4'd5, -32'sd8);
		issue_action(KIND_SAVE, 4'd0, 32'h8000_0000);
		issue_action(KIND_SAVE, 4'd8, -32'sd4);
		issue_action(KIND_SAVE, 4'd1, -32'sd512);
		issue_action(KIND_SAVE, 4'd3, 32'd0);
		issue_action(KIND_SAVE, 4'd3, 32'd4);
		issue_action(KIND_SAVE, 4'd3, -32'sd2);
		issue_action(KIND_SAVE, 4'd6, 32'h7fff_ffff);
		issue_action(KIND_RESTORE, 4'd0, 32'd0);
		issue_action(KIND_RESTORE, 4'd8, $urandom);
		issue_action(KIND_UNUSED, 4'd2, 32'd16);
		issue_action(KIND_UNUSED, 4'd8, 32'hffff_ffff);
		issue_action(KIND_UNUSED, 4'd15, 32'd0);
		issue_action(KIND_DEF_CFA, 4'd9, 32'd4);
		issue_action(KIND_SAVE, 4'd12, -32'sd4);
		issue_action(KIND_RESTORE, 4'd15, 32'hffff_ffff);
		drain();

		// random: mostly valid actions with random content, the rest anything at all
		for (int n = 0; n < RandomActions; n++) begin
			if (n % 20 == 0)
				burst = ($urandom_range(0, 3) == 0);
			if (n == RandomActions / 2)
				drain();
			if ($urandom_range(0, 3) != 0) begin
				regno = RegW'($urandom_range(0, 8));
				case ($urandom_range(0, 2))
					0: begin
						kind = KIND_DEF_CFA;
						off = $urandom >> $urandom_range(0, 31);
					end
					1: begin
						kind = KIND_SAVE;
						mag = $urandom >> $urandom_range(3, 31);
						if (mag == '0)
							mag = OffW'(1);
						off = 32'd0 - (mag << 2);
					end
					default: begin
						kind = KIND_RESTORE;
						off = $urandom;
					end
				endcase
			end else begin
				kind = 2'($urandom_range(0, 3));
				regno = RegW'($urandom_range(0, 15));
				off = $urandom;
			end
			issue_action(kind, regno, off);
		end
		drain();
		repeat (12) @(posedge clk);

		$display("%0d actions sent, %0d result bytes checked, %0d of them error results",
			action_count, byte_count, err_result_count);
		$display("mismatches: %0d, bytes left unmatched: %0d", fail_count, pending);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
